// ----- rtl/grc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package grc_pkg;

	localparam int DEF_SCREEN_W = 320;
	localparam int DEF_SCREEN_H = 240;
	localparam int DEF_MAP_SIDE = 32;
	localparam int DEF_TEX_SIZE = 32;

	// shared divider: numerator and denominator widths
	localparam int DIV_NW = 52;
	localparam int DIV_DW = 24;
	localparam int DIV_CW = $clog2(DIV_NW);

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_CAST  = 1'b1;

	localparam logic [2:0] TILE_EMPTY = 3'd0;
	localparam logic [2:0] TILE_RED   = 3'd1;
	localparam logic [2:0] TILE_GREEN = 3'd2;
	localparam logic [2:0] TILE_BLUE  = 3'd3;
	localparam logic [2:0] TILE_WHITE = 3'd4;

	typedef enum logic [CFG_IW-1:0] {
		CFG_PLAYER_X,
		CFG_PLAYER_Y,
		CFG_VIEW_DIR_X,
		CFG_VIEW_DIR_Y,
		CFG_PLANE_X,
		CFG_PLANE_Y,
		CFG_TEXTURED,
		CFG_RENDER_LIMIT
	} cfg_idx_t;

	typedef struct packed {
		logic [14:0]        player_x;
		logic [14:0]        player_y;
		logic signed [15:0] view_dir_x;
		logic signed [15:0] view_dir_y;
		logic signed [15:0] camera_plane_x;
		logic signed [15:0] camera_plane_y;
		logic               textured_mode;
		logic [15:0]        render_limit;
	} cfg_t;

	typedef struct packed {
		logic       cast;
		logic [9:0] column;
		logic [4:0] cell_x;
		logic [4:0] cell_y;
		logic [2:0] cell_kind;
	} item_t;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quot;
		logic [DIV_DW-1:0] rem;
	} div_rsp_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_CAM,
		S_RAY_X,
		S_RAY_Y,
		S_DDX,
		S_DDX_W,
		S_DDY,
		S_DDY_W,
		S_INIT_X,
		S_INIT_Y,
		S_WALK,
		S_READ,
		S_NUM,
		S_PERP,
		S_PERP_W,
		S_HGT,
		S_HGT_W,
		S_TEX,
		S_MUL_HI,
		S_WDIV,
		S_WDIV_W,
		S_TEXCOL,
		S_FIN
	} back_state_t;

endpackage

`default_nettype wire

// ----- rtl/grid_ray_caster_column_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// input     in_valid / in_stall   action, column, cell_x, cell_y, cell_kind
// output    out_valid / out_stall span_top, span_bottom, side_hit, hit_kind,
//                                 perp_distance, red, green, blue, texture_u
// config    cfg_we                cfg_index, cfg_data
//
// The back end does a tile write as it pops it from the queue. Camera x comes
// from a reciprocal multiply; five divisions (two step lengths, distance, wall
// height, wall offset) share one divider, each as issue, quotient bits and
// pick-up. A division is skipped when its ray component or the distance is zero,
// and the wall offset division runs only in textured mode. The walk reads the
// tile store once per crossing. After reset the back end sweeps the 1024-entry
// tile store to empty; in_stall stays high during the sweep.
// A two-entry queue parts the front from the back; the result register
// lets the back run on while a result waits on out_stall.

module grid_ray_caster_column_top
	import grc_pkg::*;
#(
	parameter int SCREEN_W = DEF_SCREEN_W,
	parameter int SCREEN_H = DEF_SCREEN_H,
	parameter int MAP_SIDE = DEF_MAP_SIDE,
	parameter int TEX_SIZE = DEF_TEX_SIZE
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CFG_IW-1:0]  cfg_index,
	input  logic [CFG_DW-1:0]  cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic [9:0]         column,
	input  logic [4:0]         cell_x,
	input  logic [4:0]         cell_y,
	input  logic [2:0]         cell_kind,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] span_top,
	output logic signed [15:0] span_bottom,
	output logic               side_hit,
	output logic [2:0]         hit_kind,
	output logic [15:0]        perp_distance,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic [6:0]         texture_u
);

	cfg_t  cfg_q;
	logic  q_valid;
	item_t q_item;
	logic  q_pop;
	logic  clearing;

	// configuration registers; the user must write them only while the block is idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.player_x       <= 15'd16384;
			cfg_q.player_y       <= 15'd16384;
			cfg_q.view_dir_x     <= -16'sd16384;
			cfg_q.view_dir_y     <= 16'sd0;
			cfg_q.camera_plane_x <= 16'sd0;
			cfg_q.camera_plane_y <= 16'sd10813;
			cfg_q.textured_mode  <= 1'b0;
			cfg_q.render_limit   <= 16'd20480;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PLAYER_X:     cfg_q.player_x       <= cfg_data[14:0];
				CFG_PLAYER_Y:     cfg_q.player_y       <= cfg_data[14:0];
				CFG_VIEW_DIR_X:   cfg_q.view_dir_x     <= cfg_data;
				CFG_VIEW_DIR_Y:   cfg_q.view_dir_y     <= cfg_data;
				CFG_PLANE_X:      cfg_q.camera_plane_x <= cfg_data;
				CFG_PLANE_Y:      cfg_q.camera_plane_y <= cfg_data;
				CFG_TEXTURED:     cfg_q.textured_mode  <= cfg_data[0];
				CFG_RENDER_LIMIT: cfg_q.render_limit   <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: accept each transaction, tag it as tile write or cast, queue it
	grc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.column    (column),
		.cell_x    (cell_x),
		.cell_y    (cell_y),
		.cell_kind (cell_kind),
		.hold      (clearing),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	// back: tile store, ray setup, grid walk, distance and texture math
	grc_back #(
		.SCREEN_W (SCREEN_W),
		.SCREEN_H (SCREEN_H),
		.MAP_SIDE (MAP_SIDE),
		.TEX_SIZE (TEX_SIZE)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.clearing      (clearing),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.span_top      (span_top),
		.span_bottom   (span_bottom),
		.side_hit      (side_hit),
		.hit_kind      (hit_kind),
		.perp_distance (perp_distance),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.texture_u     (texture_u)
	);

`ifndef SYNTHESIS
	// no input transaction while the tile store sweep runs
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> in_stall)
		else $error("input accepted during tile store sweep");

	// a miss or a default tile carries no atlas column
	a_miss_no_texture: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (hit_kind == TILE_EMPTY || hit_kind > TILE_WHITE) |-> texture_u == 7'd0)
		else $error("texture column on a tile without texture");

	// textured mode blanks the flat colour
	a_textured_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cfg_q.textured_mode |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
		else $error("flat colour in textured mode");

	// zero distance gives the full span
	a_zero_dist_span: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && perp_distance == 16'd0 |-> span_top == -16'sd32768
			&& span_bottom == 16'sd32767)
		else $error("span wrong at zero distance");
`endif

endmodule

`default_nettype wire

// ----- rtl/grc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module grc_div
	import grc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_NW-1:0] n_q;
	logic [DIV_DW-1:0] d_q;
	logic [DIV_DW-1:0] r_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	// restoring division, one quotient bit per cycle
	assign trial = {r_q, n_q[DIV_NW-1]};
	assign fits  = (trial >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q <= req.num;
			d_q <= req.den;
			r_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[DIV_NW-2:0], fits};
			r_q <= fits ? DIV_DW'(trial - {1'b0, d_q}) : trial[DIV_DW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = n_q;
	assign rsp.rem  = r_q;

endmodule

`default_nettype wire

// ----- rtl/grc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module grc_front
	import grc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic [9:0] column,
	input  logic [4:0] cell_x,
	input  logic [4:0] cell_y,
	input  logic [2:0] cell_kind,
	input  logic       hold,
	output logic       q_valid,
	output item_t      q_item,
	input  logic       q_pop
);

	item_t      fifo_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      item;

	assign in_stall = hold || (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;

	always_comb begin
		item.cast      = (action == ACT_CAST);
		item.column    = column;
		item.cell_x    = cell_x;
		item.cell_y    = cell_y;
		item.cell_kind = cell_kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (q_pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_q] <= item;
	end

	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = fifo_q[rd_q];

endmodule

`default_nettype wire

// ----- rtl/grc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module grc_back
	import grc_pkg::*;
#(
	parameter int SCREEN_W = DEF_SCREEN_W,
	parameter int SCREEN_H = DEF_SCREEN_H,
	parameter int MAP_SIDE = DEF_MAP_SIDE,
	parameter int TEX_SIZE = DEF_TEX_SIZE
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               q_valid,
	input  item_t              q_item,
	output logic               q_pop,
	output logic               clearing,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] span_top,
	output logic signed [15:0] span_bottom,
	output logic               side_hit,
	output logic [2:0]         hit_kind,
	output logic [15:0]        perp_distance,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic [6:0]         texture_u
);

	localparam int HALF_ROWS = SCREEN_H * 128;
	// reciprocal of the screen width, exact for numerators below 2^25
	localparam logic [31:0] CAM_RECIP =
		32'(((64'd1 << 35) + 64'(SCREEN_W) - 64'd1) / 64'(SCREEN_W));

	back_state_t state_q, state_d;
	div_req_t    div_req;
	div_rsp_t    div_rsp;

	logic [9:0]         clr_q;
	logic [9:0]         col_q;
	logic signed [21:0] cam_q;
	logic signed [23:0] rx_q, ry_q;
	logic [41:0]        ddx_q, ddy_q, dx_q, dy_q, len_q;
	logic signed [17:0] mx_q, my_q;
	logic               hor_q;
	logic [2:0]         kind_q;
	logic               inmap_q;
	logic [2:0]         rd_q;
	logic signed [27:0] num_q;
	logic signed [23:0] d_q;
	logic [15:0]        perp_q;
	logic signed [15:0] top_q, bot_q;
	logic [9:0]         base_q;
	logic [27:0]        nabs_q;
	logic [23:0]        oabs_q, dabs_q;
	logic               neg_q;
	logic [DIV_NW-1:0]  prod_q;
	logic [9:0]         wall_q;
	logic [6:0]         texu_q;
	logic               out_valid_q;

	logic [2:0] mem [1024];

	// combinational helpers
	logic signed [11:0] cam_t;
	logic [11:0]        cam_mag;
	logic [42:0]        cam_prod;
	logic [23:0]        rx_abs, ry_abs;
	logic signed [37:0] ray_prod;
	logic [21:0]        lim;
	logic               walk_go, past_lim;
	logic               step_x;
	logic signed [17:0] nmx, nmy;
	logic               nin;
	logic signed [39:0] nperp;
	logic [39:0]        nperp_abs;
	logic [10:0]        frac_sel;
	logic [41:0]        frac_prod;
	logic               init_zero;
	logic               load_out;
	logic               mem_we;
	logic [9:0]         mem_wa;
	logic [2:0]         mem_wd;
	logic signed [27:0] vt, vb;
	logic signed [19:0] vt_s, vb_s;
	logic [25:0]        hh;
	logic [15:0]        tex_prod;
	logic [5:0]         tex_x, tex_f;
	logic               flip;
	logic [9:0]         qlo;
	logic [23:0]        other_abs_c, dsel_abs_c;
	logic signed [23:0] other_c, dsel_c;

	function automatic logic [23:0] flat_rgb(input logic [2:0] k);
		logic [23:0] v;
		case (k)
			TILE_RED:   v = 24'hFF0000;
			TILE_GREEN: v = 24'h00FF00;
			TILE_BLUE:  v = 24'h0000FF;
			TILE_WHITE: v = 24'hFFFFFF;
			default:    v = 24'hFFFF00;
		endcase
		return v;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		logic signed [15:0] r;
		if (v > 20'sd32767)
			r = 16'sh7FFF;
		else if (v < -20'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

	grc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cam_t   = $signed({1'b0, col_q, 1'b0}) - $signed(12'(SCREEN_W));
	assign cam_mag = cam_t[11] ? 12'(-cam_t) : 12'(cam_t);
	// |camera x| = floor(|2*col - W| * 2^14 / W) by reciprocal multiplication
	assign cam_prod = 43'(cam_mag[10:0]) * 43'(CAM_RECIP);
	assign rx_abs  = rx_q[23] ? 24'(-rx_q) : 24'(rx_q);
	assign ry_abs  = ry_q[23] ? 24'(-ry_q) : 24'(ry_q);
	assign ray_prod = ((state_q == S_RAY_X) ? cfg.camera_plane_x : cfg.camera_plane_y) * cam_q;
	assign lim      = {cfg.render_limit, 6'd0};
	assign past_lim = (len_q > 42'(lim));

	assign step_x  = (dx_q < dy_q);
	assign nmx     = step_x ? (rx_q[23] ? mx_q - 18'sd1 : mx_q + 18'sd1) : mx_q;
	assign nmy     = step_x ? my_q : (ry_q[23] ? my_q - 18'sd1 : my_q + 18'sd1);
	assign nin     = !nmx[17] && !nmy[17] && (nmx < $signed(18'(MAP_SIDE)))
		&& (nmy < $signed(18'(MAP_SIDE)));
	assign walk_go = (state_q == S_WALK) && (kind_q == TILE_EMPTY) && !past_lim;

	assign nperp     = d_q[23] ? -$signed({num_q, 12'd0}) : $signed({num_q, 12'd0});
	assign nperp_abs = 40'(nperp);

	// first crossing distance along one axis
	always_comb begin
		logic [9:0] f;
		logic       neg;
		logic [41:0] dd;
		if (state_q == S_INIT_X) begin
			f   = cfg.player_x[9:0];
			neg = rx_q[23];
			dd  = ddx_q;
			init_zero = (rx_q == '0);
		end else begin
			f   = cfg.player_y[9:0];
			neg = ry_q[23];
			dd  = ddy_q;
			init_zero = (ry_q == '0);
		end
		frac_sel  = neg ? {1'b0, f} : 11'd1024 - {1'b0, f};
		frac_prod = 42'(frac_sel * dd[30:0]);
	end

	assign hh   = div_rsp.quot[26:1];
	assign vt   = $signed(28'(HALF_ROWS)) - $signed({2'b00, hh});
	assign vb   = $signed(28'(HALF_ROWS)) + $signed({2'b00, hh});
	assign vt_s = 20'(vt >>> 8);
	assign vb_s = 20'(vb >>> 8);

	assign other_c     = hor_q ? ry_q : rx_q;
	assign dsel_c      = hor_q ? rx_q : ry_q;
	assign other_abs_c = hor_q ? ry_abs : rx_abs;
	assign dsel_abs_c  = hor_q ? rx_abs : ry_abs;

	assign qlo = div_rsp.quot[9:0] + {9'd0, (div_rsp.rem != '0)};

	assign tex_prod = 16'(wall_q * 6'(TEX_SIZE));
	assign tex_x    = tex_prod[15:10];
	assign flip     = (hor_q && (rx_q <= 24'sd0)) || (!hor_q && (ry_q >= 24'sd0));
	assign tex_f    = flip ? 6'(TEX_SIZE - 1) - tex_x : tex_x;

	assign load_out = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		div_req  = '0;
		q_pop    = 1'b0;
		clearing = 1'b0;
		case (state_q)
			S_CLEAR: begin
				clearing = 1'b1;
				if (clr_q == '1)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_item.cast)
						state_d = S_CAM;
				end
			end
			S_CAM:    state_d = S_RAY_X;
			S_RAY_X:  state_d = S_RAY_Y;
			S_RAY_Y:  state_d = S_DDX;
			S_DDX: begin
				if (rx_q == '0) begin
					state_d = S_DDY;
				end else begin
					div_req.start = 1'b1;
					div_req.num   = DIV_NW'(1) << 30;
					div_req.den   = rx_abs;
					state_d       = S_DDX_W;
				end
			end
			S_DDX_W:  if (div_rsp.done) state_d = S_DDY;
			S_DDY: begin
				if (ry_q == '0) begin
					state_d = S_INIT_X;
				end else begin
					div_req.start = 1'b1;
					div_req.num   = DIV_NW'(1) << 30;
					div_req.den   = ry_abs;
					state_d       = S_DDY_W;
				end
			end
			S_DDY_W:  if (div_rsp.done) state_d = S_INIT_X;
			S_INIT_X: state_d = S_INIT_Y;
			S_INIT_Y: state_d = S_WALK;
			S_WALK:   state_d = walk_go ? S_READ : S_NUM;
			S_READ:   state_d = S_WALK;
			S_NUM:    state_d = S_PERP;
			S_PERP: begin
				if (d_q == '0 || nperp <= 40'sd0) begin
					state_d = S_HGT;
				end else begin
					div_req.start = 1'b1;
					div_req.num   = DIV_NW'(nperp_abs);
					div_req.den   = d_q[23] ? 24'(-d_q) : 24'(d_q);
					state_d       = S_PERP_W;
				end
			end
			S_PERP_W: if (div_rsp.done) state_d = S_HGT;
			S_HGT: begin
				if (perp_q == '0) begin
					state_d = S_TEX;
				end else begin
					div_req.start = 1'b1;
					div_req.num   = DIV_NW'(SCREEN_H) << 16;
					div_req.den   = DIV_DW'(perp_q);
					state_d       = S_HGT_W;
				end
			end
			S_HGT_W:  if (div_rsp.done) state_d = S_TEX;
			S_TEX: begin
				if (!cfg.textured_mode)
					state_d = S_FIN;
				else if (dsel_c == '0)
					state_d = S_TEXCOL;
				else
					state_d = S_MUL_HI;
			end
			S_MUL_HI: state_d = S_WDIV;
			S_WDIV: begin
				div_req.start = 1'b1;
				div_req.num   = prod_q;
				div_req.den   = dabs_q;
				state_d       = S_WDIV_W;
			end
			S_WDIV_W: if (div_rsp.done) state_d = S_TEXCOL;
			S_TEXCOL: state_d = S_FIN;
			S_FIN:    if (load_out) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (q_valid)
					col_q <= q_item.column;
			end
			S_CAM: begin
				cam_q <= cam_t[11] ? -$signed({1'b0, cam_prod[41:21]})
					: $signed({1'b0, cam_prod[41:21]});
			end
			S_RAY_X: rx_q <= 24'(cfg.view_dir_x) + 24'(ray_prod >>> 14);
			S_RAY_Y: ry_q <= 24'(cfg.view_dir_y) + 24'(ray_prod >>> 14);
			S_DDX:   if (rx_q == '0) ddx_q <= 42'(1) << 40;
			S_DDX_W: if (div_rsp.done) ddx_q <= 42'(div_rsp.quot[30:0]);
			S_DDY:   if (ry_q == '0) ddy_q <= 42'(1) << 40;
			S_DDY_W: if (div_rsp.done) ddy_q <= 42'(div_rsp.quot[30:0]);
			S_INIT_X: begin
				dx_q   <= init_zero ? {1'b0, frac_sel, 30'd0} : 42'(frac_prod >> 10);
				mx_q   <= $signed({13'd0, cfg.player_x[14:10]});
				my_q   <= $signed({13'd0, cfg.player_y[14:10]});
				len_q  <= '0;
				hor_q  <= 1'b0;
				kind_q <= TILE_EMPTY;
			end
			S_INIT_Y: dy_q <= init_zero ? {1'b0, frac_sel, 30'd0} : 42'(frac_prod >> 10);
			S_WALK: begin
				if (walk_go) begin
					hor_q   <= step_x;
					inmap_q <= nin;
					mx_q    <= nmx;
					my_q    <= nmy;
					if (step_x) begin
						len_q <= dx_q;
						dx_q  <= dx_q + ddx_q;
					end else begin
						len_q <= dy_q;
						dy_q  <= dy_q + ddy_q;
					end
				end
			end
			S_READ: kind_q <= inmap_q ? rd_q : TILE_EMPTY;
			S_NUM: begin
				if (past_lim)
					kind_q <= TILE_EMPTY;
				texu_q <= '0;
				if (hor_q) begin
					num_q <= $signed({mx_q, 10'd0}) - $signed({13'd0, cfg.player_x})
						+ (rx_q[23] ? 28'sd1024 : 28'sd0);
					d_q   <= rx_q;
				end else begin
					num_q <= $signed({my_q, 10'd0}) - $signed({13'd0, cfg.player_y})
						+ (ry_q[23] ? 28'sd1024 : 28'sd0);
					d_q   <= ry_q;
				end
			end
			S_PERP: begin
				if (d_q == '0)
					perp_q <= 16'hFFFF;
				else if (nperp <= 40'sd0)
					perp_q <= '0;
			end
			S_PERP_W: begin
				if (div_rsp.done)
					perp_q <= (|div_rsp.quot[DIV_NW-1:16]) ? 16'hFFFF : div_rsp.quot[15:0];
			end
			S_HGT: begin
				if (perp_q == '0) begin
					top_q <= 16'sh8000;
					bot_q <= 16'sh7FFF;
				end
			end
			S_HGT_W: begin
				if (div_rsp.done) begin
					top_q <= sat16(vt_s);
					bot_q <= sat16(vb_s);
				end
			end
			S_TEX: begin
				base_q <= hor_q ? cfg.player_y[9:0] : cfg.player_x[9:0];
				wall_q <= hor_q ? cfg.player_y[9:0] : cfg.player_x[9:0];
				nabs_q <= num_q[27] ? 28'(-num_q) : 28'(num_q);
				oabs_q <= other_abs_c;
				dabs_q <= dsel_abs_c;
				neg_q  <= num_q[27] ^ other_c[23] ^ dsel_c[23];
				prod_q <= DIV_NW'((num_q[27] ? 28'(-num_q) : 28'(num_q)) * other_abs_c[11:0]);
			end
			S_MUL_HI: prod_q <= prod_q + (DIV_NW'(nabs_q * oabs_q[23:12]) << 12);
			S_WDIV_W: begin
				if (div_rsp.done)
					wall_q <= base_q + (neg_q ? 10'(-qlo) : div_rsp.quot[9:0]);
			end
			S_TEXCOL: begin
				if (kind_q >= TILE_RED && kind_q <= TILE_WHITE)
					texu_q <= 7'({2'(kind_q - TILE_RED), 5'd0}) + 7'(tex_f);
			end
			default: ;
		endcase
	end

	// tile store
	always_comb begin
		mem_we = 1'b0;
		mem_wa = {q_item.cell_y, q_item.cell_x};
		mem_wd = q_item.cell_kind;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = TILE_EMPTY;
		end else if (state_q == S_IDLE && q_valid && !q_item.cast) begin
			mem_we = (6'(q_item.cell_x) < 6'(MAP_SIDE)) && (6'(q_item.cell_y) < 6'(MAP_SIDE));
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (walk_go)
			rd_q <= mem[{nmy[4:0], nmx[4:0]}];
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			logic [23:0] rgb;
			rgb = cfg.textured_mode ? 24'd0
				: flat_rgb((kind_q >= TILE_RED && kind_q <= TILE_WHITE) ? kind_q : TILE_EMPTY);
			span_top      <= top_q;
			span_bottom   <= bot_q;
			side_hit      <= hor_q;
			hit_kind      <= kind_q;
			perp_distance <= perp_q;
			red           <= hor_q ? {1'b0, rgb[23:17]} : rgb[23:16];
			green         <= hor_q ? {1'b0, rgb[15:9]} : rgb[15:8];
			blue          <= hor_q ? {1'b0, rgb[7:1]} : rgb[7:0];
			texture_u     <= texu_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire
